/* hw/rtl/ptq_pkg.sv */
// ----------------------------------------------------------------------------
// ptq_pkg: shared types, codes and microprogram
// Word layouts, status codes, entry layout and the control store of the
// price/time threshold query sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ptq_pkg;

    localparam logic [1:0] OP_CLEAR      = 2'd0;
    localparam logic [1:0] OP_APPEND     = 2'd1;
    localparam logic [1:0] OP_FIRST_TIME = 2'd2;
    localparam logic [1:0] OP_MAX_PRICE  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] entry_time;
        logic [31:0] entry_price;
        logic [31:0] query_key;
    } req_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] answer;
    } rsp_word_t;

    // one table row; pmax and tmax are running maxima up to this row
    typedef struct packed {
        logic [31:0] etime;
        logic [31:0] price;
        logic [31:0] pmax;
        logic [31:0] tmax;
    } entry_t;

    typedef enum logic [3:0] {
        UOP_WAIT,
        UOP_CLEAR,
        UOP_APPEND,
        UOP_SINIT,
        UOP_SREAD,
        UOP_SCMP,
        UOP_SEND,
        UOP_NOP,
        UOP_TAKE_TIME,
        UOP_SCAN_INIT,
        UOP_SCAN_READ,
        UOP_SCAN_ACC,
        UOP_TAKE_BEST,
        UOP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_DISPATCH,
        C_SEARCH_DONE,
        C_MISS,
        C_OP_MAX,
        C_SCAN_DONE,
        C_OUT_BUSY
    } cond_t;

    typedef logic [3:0] step_t;

    localparam step_t S_CLEAR     = 4'd0;
    localparam step_t S_APPEND    = 4'd1;
    localparam step_t S_SINIT     = 4'd2;
    localparam step_t S_STEST     = 4'd3;
    localparam step_t S_SCMP      = 4'd4;
    localparam step_t S_SEND      = 4'd5;
    localparam step_t S_BRANCH    = 4'd6;
    localparam step_t S_TIME      = 4'd7;
    localparam step_t S_SCAN_INIT = 4'd8;
    localparam step_t S_SCAN_TEST = 4'd9;
    localparam step_t S_SCAN_ACC  = 4'd10;
    localparam step_t S_SCAN_END  = 4'd11;
    localparam step_t S_EMIT      = 4'd12;
    localparam step_t S_IDLE      = 4'd13;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic search_done;
        logic miss;
        logic op_max;
        logic scan_done;
        logic out_busy;
    } flags_t;

    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t cw;
        case (step)
            S_CLEAR:     cw = ctrl_word_t'{UOP_CLEAR,     C_ALWAYS,      S_EMIT};
            S_APPEND:    cw = ctrl_word_t'{UOP_APPEND,    C_ALWAYS,      S_EMIT};
            S_SINIT:     cw = ctrl_word_t'{UOP_SINIT,     C_NEXT,        S_STEST};
            S_STEST:     cw = ctrl_word_t'{UOP_SREAD,     C_SEARCH_DONE, S_SEND};
            S_SCMP:      cw = ctrl_word_t'{UOP_SCMP,      C_ALWAYS,      S_STEST};
            S_SEND:      cw = ctrl_word_t'{UOP_SEND,      C_MISS,        S_EMIT};
            S_BRANCH:    cw = ctrl_word_t'{UOP_NOP,       C_OP_MAX,      S_SCAN_INIT};
            S_TIME:      cw = ctrl_word_t'{UOP_TAKE_TIME, C_ALWAYS,      S_EMIT};
            S_SCAN_INIT: cw = ctrl_word_t'{UOP_SCAN_INIT, C_NEXT,        S_SCAN_TEST};
            S_SCAN_TEST: cw = ctrl_word_t'{UOP_SCAN_READ, C_SCAN_DONE,   S_SCAN_END};
            S_SCAN_ACC:  cw = ctrl_word_t'{UOP_SCAN_ACC,  C_ALWAYS,      S_SCAN_TEST};
            S_SCAN_END:  cw = ctrl_word_t'{UOP_TAKE_BEST, C_ALWAYS,      S_EMIT};
            S_EMIT:      cw = ctrl_word_t'{UOP_EMIT,      C_OUT_BUSY,    S_EMIT};
            S_IDLE:      cw = ctrl_word_t'{UOP_WAIT,      C_DISPATCH,    S_IDLE};
            default:     cw = ctrl_word_t'{UOP_WAIT,      C_ALWAYS,      S_IDLE};
        endcase
        return cw;
    endfunction

    function automatic step_t dispatch_rom(input logic [1:0] opcode);
        step_t s;
        case (opcode)
            OP_CLEAR:  s = S_CLEAR;
            OP_APPEND: s = S_APPEND;
            default:   s = S_SINIT;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ptq_useq.sv */
// ----------------------------------------------------------------------------
// ptq_useq: microprogram sequencer
// Step counter, control store lookup, opcode dispatch and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_useq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire logic [1:0]          opcode,
    input  wire ptq_pkg::flags_t     flags,
    output ptq_pkg::ctrl_word_t      cw,
    output logic                     req_stall,
    output logic                     req_accept
);

    ptq_pkg::step_t pc_reg;
    ptq_pkg::step_t pc_next;
    ptq_pkg::step_t pc_inc;
    logic           take;

    assign cw         = ptq_pkg::ucode_rom(pc_reg);
    assign req_stall  = (cw.uop != ptq_pkg::UOP_WAIT);
    assign req_accept = req_valid && !req_stall;
    assign pc_inc     = pc_reg + 4'd1;

    always_comb
    begin
        case (cw.cond)
            ptq_pkg::C_NEXT:        take = 1'b0;
            ptq_pkg::C_ALWAYS:      take = 1'b1;
            ptq_pkg::C_SEARCH_DONE: take = flags.search_done;
            ptq_pkg::C_MISS:        take = flags.miss;
            ptq_pkg::C_OP_MAX:      take = flags.op_max;
            ptq_pkg::C_SCAN_DONE:   take = flags.scan_done;
            ptq_pkg::C_OUT_BUSY:    take = flags.out_busy;
            default:                take = 1'b0;
        endcase

        if (cw.cond == ptq_pkg::C_DISPATCH)
        begin
            pc_next = req_accept ? ptq_pkg::dispatch_rom(opcode) : pc_reg;
        end
        else if (take)
        begin
            pc_next = cw.target;
        end
        else
        begin
            pc_next = pc_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ptq_pkg::S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ptq_dpath.sv */
// ----------------------------------------------------------------------------
// ptq_dpath: table datapath
// Entry memory with running maxima, search bounds, suffix scan and the
// result register, driven by one control word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_dpath #(
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ptq_pkg::ctrl_word_t cw,
    input  wire logic                req_accept,
    input  wire ptq_pkg::req_word_t  req_word,
    input  wire logic                rsp_stall,
    output ptq_pkg::flags_t          flags,
    output logic                     rsp_valid,
    output ptq_pkg::rsp_word_t       rsp_word
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

    ptq_pkg::entry_t mem [MAX_ENTRIES];
    ptq_pkg::entry_t rdata_reg;
    ptq_pkg::entry_t wr_entry;

    logic [1:0]    op_reg;
    logic [31:0]   time_in_reg;
    logic [31:0]   price_in_reg;
    logic [31:0]   key_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   run_pmax_reg, run_pmax_next;
    logic [31:0]   run_tmax_reg, run_tmax_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [31:0]   best_reg, best_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [31:0]   res_answer_reg, res_answer_next;
    logic          rsp_valid_reg, rsp_valid_next;
    ptq_pkg::rsp_word_t rsp_word_reg, rsp_word_next;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid_calc;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic          full;
    logic [31:0]   search_field;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = mid_sum[CW:1];
    assign full     = (count_reg == FULL_COUNT);
    assign search_field = flags.op_max ? rdata_reg.tmax : rdata_reg.pmax;

    assign flags.search_done = (lo_reg >= hi_reg);
    assign flags.miss        = (lo_reg == count_reg);
    assign flags.op_max      = (op_reg == ptq_pkg::OP_MAX_PRICE);
    assign flags.scan_done   = (idx_reg >= count_reg);
    assign flags.out_busy    = rsp_valid_reg && rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    always_comb
    begin
        count_next      = count_reg;
        run_pmax_next   = run_pmax_reg;
        run_tmax_next   = run_tmax_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        idx_next        = idx_reg;
        best_next       = best_reg;
        res_status_next = res_status_reg;
        res_answer_next = res_answer_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_word_next   = rsp_word_reg;
        rd_en           = 1'b0;
        rd_addr         = mid_calc[IW-1:0];
        wr_en           = 1'b0;
        wr_entry.etime  = time_in_reg;
        wr_entry.price  = price_in_reg;
        wr_entry.pmax   = (count_reg == '0 || price_in_reg > run_pmax_reg)
                          ? price_in_reg : run_pmax_reg;
        wr_entry.tmax   = (count_reg == '0 || time_in_reg > run_tmax_reg)
                          ? time_in_reg : run_tmax_reg;

        case (cw.uop)
            ptq_pkg::UOP_CLEAR:
            begin
                count_next      = '0;
                res_status_next = ptq_pkg::ST_OK;
                res_answer_next = '0;
            end
            ptq_pkg::UOP_APPEND:
            begin
                res_answer_next = '0;
                if (full)
                begin
                    res_status_next = ptq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en           = 1'b1;
                    count_next      = count_reg + CW'(1);
                    run_pmax_next   = wr_entry.pmax;
                    run_tmax_next   = wr_entry.tmax;
                    res_status_next = ptq_pkg::ST_OK;
                end
            end
            ptq_pkg::UOP_SINIT:
            begin
                lo_next = '0;
                hi_next = count_reg;
            end
            ptq_pkg::UOP_SREAD:
            begin
                rd_en    = 1'b1;
                rd_addr  = mid_calc[IW-1:0];
                mid_next = mid_calc;
            end
            ptq_pkg::UOP_SCMP:
            begin
                if (search_field >= key_reg)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + CW'(1);
                end
            end
            ptq_pkg::UOP_SEND:
            begin
                rd_en           = 1'b1;
                rd_addr         = lo_reg[IW-1:0];
                idx_next        = lo_reg;
                res_status_next = ptq_pkg::ST_NOT_FOUND;
                res_answer_next = '0;
            end
            ptq_pkg::UOP_TAKE_TIME:
            begin
                res_status_next = ptq_pkg::ST_OK;
                res_answer_next = rdata_reg.etime;
            end
            ptq_pkg::UOP_SCAN_INIT:
            begin
                best_next = rdata_reg.price;
                idx_next  = idx_reg + CW'(1);
            end
            ptq_pkg::UOP_SCAN_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[IW-1:0];
            end
            ptq_pkg::UOP_SCAN_ACC:
            begin
                if (rdata_reg.price > best_reg)
                begin
                    best_next = rdata_reg.price;
                end
                idx_next = idx_reg + CW'(1);
            end
            ptq_pkg::UOP_TAKE_BEST:
            begin
                res_status_next = ptq_pkg::ST_OK;
                res_answer_next = best_reg;
            end
            ptq_pkg::UOP_EMIT:
            begin
                if (!flags.out_busy)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_word_next.status = res_status_reg;
                    rsp_word_next.answer = res_answer_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IW-1:0]] <= wr_entry;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            op_reg       <= req_word.opcode;
            time_in_reg  <= req_word.entry_time;
            price_in_reg <= req_word.entry_price;
            key_reg      <= req_word.query_key;
        end
        run_pmax_reg   <= run_pmax_next;
        run_tmax_reg   <= run_tmax_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        idx_reg        <= idx_next;
        best_reg       <= best_next;
        res_status_reg <= res_status_next;
        res_answer_reg <= res_answer_next;
        rsp_word_reg   <= rsp_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/price_time_threshold_query.sv */
// ----------------------------------------------------------------------------
// price_time_threshold_query: time/price table with threshold queries
// Appends (time, price) entries, clears the table, and answers the earliest
// time reaching a price and the largest price from a start time onward.
// ----------------------------------------------------------------------------
// One word is taken at a time and gives exactly one response word. Clear and
// append update the table and then emit the response. Both queries run a
// binary search over the running maxima kept with each entry: at most
// ceil(log2(n+1)) probes for n entries, through the single registered read
// port of the entry memory. A max-price query then scans each entry from the
// found entry to the end of the table through the same port. A pending
// response may wait on rsp_stall while the next request word is already
// accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module price_time_threshold_query #(
    parameter int MAX_ENTRIES = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire ptq_pkg::req_word_t req_word,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output ptq_pkg::rsp_word_t      rsp_word
);

    ptq_pkg::ctrl_word_t cw;
    ptq_pkg::flags_t     flags;
    logic                req_accept;

    ptq_useq u_useq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .opcode     (req_word.opcode),
        .flags      (flags),
        .cw         (cw),
        .req_stall  (req_stall),
        .req_accept (req_accept)
    );

    ptq_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cw         (cw),
        .req_accept (req_accept),
        .req_word   (req_word),
        .rsp_stall  (rsp_stall),
        .flags      (flags),
        .rsp_valid  (rsp_valid),
        .rsp_word   (rsp_word)
    );

endmodule

`default_nettype wire

/* hw/rtl/ptq_checker.sv */
// ----------------------------------------------------------------------------
// ptq_checker: port-level checks
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_stall,
    input wire ptq_pkg::req_word_t req_word,
    input wire logic               rsp_valid,
    input wire logic               rsp_stall,
    input wire ptq_pkg::rsp_word_t rsp_word
);

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("stalled response word changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous one in progress");

    a_answer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.status != ptq_pkg::ST_OK |-> rsp_word.answer == 32'd0)
        else $error("nonzero answer with error status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_word.status == ptq_pkg::ST_OK
                   || rsp_word.status == ptq_pkg::ST_NOT_FOUND
                   || rsp_word.status == ptq_pkg::ST_FULL)
        else $error("undefined status code");

    a_full_from_append: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_word.opcode != ptq_pkg::OP_APPEND
        |=> !(rsp_valid && !$past(rsp_valid && rsp_stall)
              && rsp_word.status == ptq_pkg::ST_FULL))
        else $error("full status without an append");

endmodule

bind price_time_threshold_query ptq_checker u_ptq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
);

`default_nettype wire
